FILE: rtl/fpt_pkg.sv
// Package for the fan PWM and tachometer monitor.
// Holds widths, reset values, register indexes, controller types and command structs.
// No dependencies.
`timescale 1ns / 1ps

package fpt_pkg;

  localparam int PERIOD_BITS = 16;
  localparam int TOP_W       = 8;
  localparam int NUM_W       = 30;
  localparam int RPM_W       = 16;
  localparam int THR_W       = 16;
  localparam int DIV_CNT_W   = $clog2(NUM_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NUM_W;

  localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_NUMERATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OK_THRESHOLD  = 2'd2;

  localparam logic [1:0] ENC_DEC = 2'd1;
  localparam logic [1:0] ENC_INC = 2'd2;

  localparam logic [TOP_W-1:0]       PWM_TOP_RST   = 8'd199;
  localparam logic [NUM_W-1:0]       NUM_RST       = 30'd30000000;
  localparam logic [THR_W-1:0]       THR_RST       = 16'd2400;
  localparam logic [TOP_W-1:0]       DUTY_RST      = 8'd50;
  localparam logic [PERIOD_BITS-1:0] PERIOD_RST    = PERIOD_BITS'(6800);
  localparam logic [RPM_W-1:0]       RPM_RST       = 16'd4411;
  localparam logic [RPM_W-1:0]       RPM_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUB
  } ctrl_state_e;

  typedef struct packed {
    logic step;       // apply the accepted word to the state
    logic div_start;  // load the divider
    logic div_step;   // one quotient bit
    logic load_out;   // capture the result word
  } cmd_t;

  typedef struct packed {
    logic need_div;   // the word on the input needs a new rpm
    logic div_last;   // final quotient bit this cycle
  } status_t;

endpackage

FILE: rtl/fpt_item_if.sv
// Input channel of the fan monitor: one word of ticks, tach edge and encoder step.
// Depends on nothing.
`timescale 1ns / 1ps

interface fpt_item_if;
  logic       valid;
  logic       ready;
  logic       pwm_tick;
  logic       timer_tick;
  logic       tach_edge;
  logic [1:0] enc_step;

  modport source (output valid, pwm_tick, timer_tick, tach_edge, enc_step, input ready);
  modport sink   (input valid, pwm_tick, timer_tick, tach_edge, enc_step, output ready);
endinterface

FILE: rtl/fpt_result_if.sv
// Output channel of the fan monitor: one status word per accepted input word.
// Depends on nothing.
`timescale 1ns / 1ps

interface fpt_result_if;
  logic        valid;
  logic        ready;
  logic        pwm_out;
  logic [7:0]  duty_value;
  logic [15:0] period_ticks;
  logic [15:0] rpm;
  logic        fan_ok;
  logic        stalled;
  logic        buzzer;

  modport source (output valid, pwm_out, duty_value, period_ticks, rpm, fan_ok, stalled,
                  buzzer, input ready);
  modport sink   (input valid, pwm_out, duty_value, period_ticks, rpm, fan_ok, stalled,
                  buzzer, output ready);
endinterface

FILE: rtl/fan_pwm_tach_monitor.sv
// Top level of the fan PWM and tachometer monitor.
// Depends on fpt_pkg, fpt_item_if, fpt_result_if, fpt_ctrl and fpt_datapath.
`timescale 1ns / 1ps

// Each input word carries a PWM tick, a timer tick, a tach edge flag and an encoder step,
// and produces exactly one status word. A word that needs no divide goes straight to the
// output register, so such words stream at one per cycle while the output side keeps
// up; it lets a new word be accepted in the same cycle that the previous status word is
// taken. A word with a tach edge, and the first word after rpm_numerator is written,
// starts a restoring divider that produces one quotient bit per cycle: such a word holds
// off the input from its accept through the 30-bit numerator's steps to its publish.
// rpm is saturated at 65535, also for a zero period. Not enforced by the block: the user
// must write configuration through the plain write port only while no word is in flight.
module fan_pwm_tach_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fpt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  fpt_item_if.sink                       item_i,
  fpt_result_if.source                   result_o
);

  fpt_pkg::cmd_t    cmd;
  fpt_pkg::status_t status;

  // The controller owns the handshakes; the datapath owns every value.
  fpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid)
  );

  fpt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pwm_tick_i     (item_i.pwm_tick),
    .timer_tick_i   (item_i.timer_tick),
    .tach_edge_i    (item_i.tach_edge),
    .enc_step_i     (item_i.enc_step),
    .cmd_i          (cmd),
    .status_o       (status),
    .pwm_out_o      (result_o.pwm_out),
    .duty_value_o   (result_o.duty_value),
    .period_ticks_o (result_o.period_ticks),
    .rpm_o          (result_o.rpm),
    .fan_ok_o       (result_o.fan_ok),
    .stalled_o      (result_o.stalled),
    .buzzer_o       (result_o.buzzer)
  );

`ifndef SYNTHESIS
  // While the divider runs, no further word may enter.
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !item_i.ready)
    else $error("input accepted while the divider runs");

  // A divide always begins with a quotient step in the next cycle.
  a_div_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> cmd.div_step)
    else $error("divider started but did not step");

  // A word that needs no divide is answered in the next cycle.
  a_fast_word_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready && !status.need_div) |=> result_o.valid)
    else $error("status word missing after a plain word");

  // Stall and buzzer are always set and cleared together.
  a_stall_buzzer_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.stalled == result_o.buzzer))
    else $error("stall and buzzer disagree");
`endif

endmodule

FILE: rtl/fpt_ctrl.sv
// Controller of the fan monitor: sequences accept, rpm division and publishing.
// Depends on fpt_pkg.
`timescale 1ns / 1ps

module fpt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_ready_i,
  input  fpt_pkg::status_t status_i,
  output fpt_pkg::cmd_t    cmd_o,
  output logic             in_ready_o,
  output logic             out_valid_o
);

  fpt_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      fpt_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.need_div) begin
            cmd_o.div_start = 1'b1;
            state_d         = fpt_pkg::ST_DIV;
          end else begin
            cmd_o.load_out = 1'b1;
          end
        end
      end
      fpt_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = fpt_pkg::ST_PUB;
        end
      end
      fpt_pkg::ST_PUB: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = fpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fpt_pkg::ST_IDLE;
      end
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

endmodule

FILE: rtl/fpt_datapath.sv
// Datapath of the fan monitor: registers, PWM and tach state, serial divider, result word.
// Depends on fpt_pkg.
`timescale 1ns / 1ps

module fpt_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fpt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fpt_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             pwm_tick_i,
  input  logic                             timer_tick_i,
  input  logic                             tach_edge_i,
  input  logic [1:0]                       enc_step_i,
  input  fpt_pkg::cmd_t                    cmd_i,
  output fpt_pkg::status_t                 status_o,
  output logic                             pwm_out_o,
  output logic [fpt_pkg::TOP_W-1:0]        duty_value_o,
  output logic [15:0]                      period_ticks_o,
  output logic [fpt_pkg::RPM_W-1:0]        rpm_o,
  output logic                             fan_ok_o,
  output logic                             stalled_o,
  output logic                             buzzer_o
);

  localparam int P = fpt_pkg::PERIOD_BITS;
  localparam int N = fpt_pkg::NUM_W;

  // Configuration registers
  logic [fpt_pkg::TOP_W-1:0] top_q;
  logic [N-1:0]              num_q;
  logic [fpt_pkg::THR_W-1:0] thr_q;
  logic                      num_dirty_q, num_dirty_d;

  // Item state
  logic [fpt_pkg::TOP_W-1:0] cnt_q, cnt_d, cmp_q, cmp_d, duty_q, duty_d, duty_enc;
  logic                      down_q, down_d;
  logic [P-1:0]              pc_q, pc_d, pc_inc, cap_q, cap_d;
  logic                      stall_q, stall_d, buzz_q, buzz_d;
  logic [fpt_pkg::RPM_W-1:0] rpm_q, rpm_d;

  // Divider
  logic [P-1:0]                  rem_q, rem_d, div_q;
  logic [N-1:0]                  quo_q, quo_d;
  logic [fpt_pkg::DIV_CNT_W-1:0] dcnt_q, dcnt_d;
  logic [P:0]                    rem_sh, rem_sub;
  logic                          ge;

  // Result register
  logic                      r_pwm_q, r_ok_q, r_stall_q, r_buzz_q;
  logic [fpt_pkg::TOP_W-1:0] r_duty_q;
  logic [15:0]               r_period_q;
  logic [fpt_pkg::RPM_W-1:0] r_rpm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= fpt_pkg::PWM_TOP_RST;
      num_q <= fpt_pkg::NUM_RST;
      thr_q <= fpt_pkg::THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpt_pkg::REG_PWM_TOP:       top_q <= cfg_wdata_i[fpt_pkg::TOP_W-1:0];
        fpt_pkg::REG_RPM_NUMERATOR: num_q <= cfg_wdata_i[N-1:0];
        fpt_pkg::REG_OK_THRESHOLD:  thr_q <= cfg_wdata_i[fpt_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A new numerator must be divided again before the next word is answered.
  always_comb begin
    num_dirty_d = num_dirty_q;
    if (cmd_i.div_start) begin
      num_dirty_d = 1'b0;
    end
    if (cfg_we_i && (cfg_idx_i == fpt_pkg::REG_RPM_NUMERATOR)) begin
      num_dirty_d = 1'b1;
    end
  end

  always_comb begin
    // Encoder step, then clamp to the top.
    duty_enc = duty_q;
    case (enc_step_i)
      fpt_pkg::ENC_DEC: if (duty_q != '0) duty_enc = duty_q - 8'd1;
      fpt_pkg::ENC_INC: if (duty_q != 8'hFF) duty_enc = duty_q + 8'd1;
      default: duty_enc = duty_q;
    endcase

    duty_d  = duty_q;
    cnt_d   = cnt_q;
    down_d  = down_q;
    cmp_d   = cmp_q;
    pc_d    = pc_q;
    cap_d   = cap_q;
    stall_d = stall_q;
    buzz_d  = buzz_q;
    pc_inc  = pc_q + 1'b1;

    if (cmd_i.step) begin
      duty_d = (duty_enc > top_q) ? top_q : duty_enc;

      if (pwm_tick_i) begin
        if (!down_q) begin
          if (cnt_q < top_q) cnt_d = cnt_q + 8'd1;
          if (cnt_d >= top_q) begin
            down_d = 1'b1;
            cmp_d  = duty_d;
          end
        end else begin
          if (cnt_q != '0) cnt_d = cnt_q - 8'd1;
          if (cnt_d == '0) down_d = 1'b0;
        end
      end

      // An edge together with a tick starts the new period at one.
      if (tach_edge_i) begin
        cap_d   = pc_q;
        pc_d    = P'(timer_tick_i);
        stall_d = 1'b0;
        buzz_d  = 1'b0;
      end else if (timer_tick_i) begin
        pc_d = pc_inc;
        if (pc_inc == '0) begin
          stall_d = 1'b1;
          buzz_d  = 1'b1;
        end
      end
    end
  end

  // Restoring division of the numerator by the captured period, one bit a cycle.
  assign rem_sh  = {rem_q, quo_q[N-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  assign status_o.need_div = tach_edge_i || num_dirty_q;
  assign status_o.div_last = cmd_i.div_step && (dcnt_q == fpt_pkg::DIV_CNT_W'(N - 1));

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dcnt_d = dcnt_q;
    rpm_d  = rpm_q;
    if (cmd_i.div_start) begin
      rem_d  = '0;
      quo_d  = num_q;
      dcnt_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d  = ge ? rem_sub[P-1:0] : rem_sh[P-1:0];
      quo_d  = {quo_q[N-2:0], ge};
      dcnt_d = dcnt_q + 1'b1;
      if (status_o.div_last) begin
        if (div_q == '0 || (quo_d >> fpt_pkg::RPM_W) != '0) begin
          rpm_d = fpt_pkg::RPM_MAX;
        end else begin
          rpm_d = quo_d[fpt_pkg::RPM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dirty_q <= 1'b0;
      duty_q      <= fpt_pkg::DUTY_RST;
      cnt_q       <= '0;
      down_q      <= 1'b0;
      cmp_q       <= fpt_pkg::DUTY_RST;
      pc_q        <= '0;
      cap_q       <= fpt_pkg::PERIOD_RST;
      stall_q     <= 1'b0;
      buzz_q      <= 1'b0;
      rpm_q       <= fpt_pkg::RPM_RST;
      dcnt_q      <= '0;
    end else begin
      num_dirty_q <= num_dirty_d;
      duty_q      <= duty_d;
      cnt_q       <= cnt_d;
      down_q      <= down_d;
      cmp_q       <= cmp_d;
      pc_q        <= pc_d;
      cap_q       <= cap_d;
      stall_q     <= stall_d;
      buzz_q      <= buzz_d;
      rpm_q       <= rpm_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.div_start) begin
      div_q <= cap_d;
    end
    if (cmd_i.load_out) begin
      r_pwm_q    <= cnt_d < cmp_d;
      r_duty_q   <= duty_d;
      r_period_q <= ((cap_d >> 16) != '0) ? 16'hFFFF : 16'(cap_d);
      r_rpm_q    <= rpm_d;
      r_ok_q     <= rpm_d >= thr_q;
      r_stall_q  <= stall_d;
      r_buzz_q   <= buzz_d;
    end
  end

  assign pwm_out_o      = r_pwm_q;
  assign duty_value_o   = r_duty_q;
  assign period_ticks_o = r_period_q;
  assign rpm_o          = r_rpm_q;
  assign fan_ok_o       = r_ok_q;
  assign stalled_o      = r_stall_q;
  assign buzzer_o       = r_buzz_q;

endmodule

FILE: tb/fpt_status_checker.sv
// Scoreboard for the fan PWM and tachometer monitor: predicts and checks every status word.
// Depends on fpt_pkg, fpt_item_if and fpt_result_if.
`timescale 1ns / 1ps

module fpt_status_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [fpt_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [fpt_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  fpt_item_if                                    item_mon,
  fpt_result_if                                  result_mon,
  output int                                     fail_count_o,
  output int                                     pending_o
);

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic        pwm_out;
    logic [7:0]  duty_value;
    logic [15:0] period_ticks;
    logic [15:0] rpm;
    logic        fan_ok;
    logic        stalled;
    logic        buzzer;
  } fan_status_t;

  // Register copies.
  logic [fpt_pkg::TOP_W-1:0]       top_q;
  logic [fpt_pkg::NUM_W-1:0]       num_q;
  logic [fpt_pkg::THR_W-1:0]       thr_q;

  // Controller state as the block should hold it.
  logic [fpt_pkg::TOP_W-1:0]       pwm_cnt_q;
  logic                            down_q;
  logic [fpt_pkg::TOP_W-1:0]       cmp_q;
  logic [fpt_pkg::TOP_W-1:0]       duty_q;
  logic [fpt_pkg::PERIOD_BITS-1:0] tick_cnt_q;
  logic [fpt_pkg::PERIOD_BITS-1:0] period_q;
  logic [fpt_pkg::RPM_W-1:0]       rpm_q;
  logic                            stall_q;
  logic                            buzz_q;

  fan_status_t                     status_q[$];
  int                              fail_cnt;
  int                              words_seen;

  task automatic report_mismatch(input string msg);
    if (fail_cnt < PRINT_CAP) $display("[%0t] status word %0d: %s", $realtime, words_seen, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Applies one accepted word to the controller state and queues the status it should give.
  task automatic predict_status(input logic pwm_tick, input logic timer_tick,
                                input logic tach_edge, input logic [1:0] enc);
    fan_status_t want;
    logic [63:0] quot;
    if (enc == fpt_pkg::ENC_DEC) begin
      if (duty_q != '0) duty_q = duty_q - 1'b1;
    end else if (enc == fpt_pkg::ENC_INC) begin
      if (duty_q != '1) duty_q = duty_q + 1'b1;
    end
    if (duty_q > top_q) duty_q = top_q;

    if (pwm_tick) begin
      if (!down_q) begin
        if (pwm_cnt_q < top_q) pwm_cnt_q = pwm_cnt_q + 1'b1;
        if (pwm_cnt_q >= top_q) begin
          down_q = 1'b1;
          cmp_q  = duty_q;
        end
      end else begin
        if (pwm_cnt_q != '0) pwm_cnt_q = pwm_cnt_q - 1'b1;
        if (pwm_cnt_q == '0) down_q = 1'b0;
      end
    end

    if (tach_edge) begin
      period_q   = tick_cnt_q;
      tick_cnt_q = timer_tick ? fpt_pkg::PERIOD_BITS'(1) : '0;
      stall_q    = 1'b0;
      buzz_q     = 1'b0;
    end else if (timer_tick) begin
      tick_cnt_q = tick_cnt_q + 1'b1;
      if (tick_cnt_q == '0) begin
        stall_q = 1'b1;
        buzz_q  = 1'b1;
      end
    end

    if (period_q == '0) begin
      rpm_q = fpt_pkg::RPM_MAX;
    end else begin
      quot  = 64'(num_q) / 64'(period_q);
      rpm_q = (quot > 64'(fpt_pkg::RPM_MAX)) ? fpt_pkg::RPM_MAX : fpt_pkg::RPM_W'(quot);
    end

    want.pwm_out      = pwm_cnt_q < cmp_q;
    want.duty_value   = duty_q;
    want.period_ticks = (64'(period_q) > 64'hFFFF) ? 16'hFFFF : 16'(period_q);
    want.rpm          = rpm_q;
    want.fan_ok       = rpm_q >= thr_q;
    want.stalled      = stall_q;
    want.buzzer       = buzz_q;
    status_q.push_back(want);
  endtask

  // Everything is sampled at the clock edge, so both channels are seen with their
  // values from before the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    fan_status_t want;
    if (!rst_ni) begin
      top_q      = fpt_pkg::PWM_TOP_RST;
      num_q      = fpt_pkg::NUM_RST;
      thr_q      = fpt_pkg::THR_RST;
      pwm_cnt_q  = '0;
      down_q     = 1'b0;
      cmp_q      = fpt_pkg::DUTY_RST;
      duty_q     = fpt_pkg::DUTY_RST;
      tick_cnt_q = '0;
      period_q   = fpt_pkg::PERIOD_RST;
      rpm_q      = fpt_pkg::RPM_RST;
      stall_q    = 1'b0;
      buzz_q     = 1'b0;
      status_q.delete();
      fail_cnt   = 0;
      words_seen = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // A status word always belongs to an earlier input word, so it is checked first.
      if (result_mon.valid && result_mon.ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("arrived with no status outstanding");
        end else begin
          want = status_q.pop_front();
          check_field("pwm_out", 32'(result_mon.pwm_out), 32'(want.pwm_out));
          check_field("duty_value", 32'(result_mon.duty_value), 32'(want.duty_value));
          check_field("period_ticks", 32'(result_mon.period_ticks), 32'(want.period_ticks));
          check_field("rpm", 32'(result_mon.rpm), 32'(want.rpm));
          check_field("fan_ok", 32'(result_mon.fan_ok), 32'(want.fan_ok));
          check_field("stalled", 32'(result_mon.stalled), 32'(want.stalled));
          check_field("buzzer", 32'(result_mon.buzzer), 32'(want.buzzer));
        end
        words_seen++;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          fpt_pkg::REG_PWM_TOP:       top_q = cfg_wdata_i[fpt_pkg::TOP_W-1:0];
          fpt_pkg::REG_RPM_NUMERATOR: num_q = cfg_wdata_i[fpt_pkg::NUM_W-1:0];
          fpt_pkg::REG_OK_THRESHOLD:  thr_q = cfg_wdata_i[fpt_pkg::THR_W-1:0];
          default: ;
        endcase
      end

      if (item_mon.valid && item_mon.ready)
        predict_status(item_mon.pwm_tick, item_mon.timer_tick, item_mon.tach_edge,
                       item_mon.enc_step);

      fail_count_o <= fail_cnt;
      pending_o    <= status_q.size();
    end
  end

endmodule

FILE: tb/fan_pwm_tach_monitor_test.sv
// Top of the fan PWM and tachometer monitor testbench: clock, reset, stimulus and verdict.
// Depends on fpt_pkg, the two channel interfaces, the block itself and fpt_status_checker.
`timescale 1ns / 1ps

module fan_pwm_tach_monitor_test;

  // Encoder codes that the package does not name: no step, and the unused code that the
  // block must treat as no step.
  localparam logic [1:0] ENC_NONE  = 2'd0;
  localparam logic [1:0] ENC_CODE3 = 2'd3;

  localparam int PHASES      = 11;
  localparam int PHASE_WORDS = 130;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [fpt_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [fpt_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             fail_count;
  int                             pending;

  // Shaping of the traffic, changed between phases while the block is idle.
  bit         src_idle;
  bit         sink_idle;
  int         pwm_odds;
  int         tick_odds;
  logic [1:0] enc_bias;

  fpt_item_if   item_if ();
  fpt_result_if result_if ();

  fan_pwm_tach_monitor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  fpt_status_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .item_mon     (item_if),
    .result_mon   (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hands one word to the block. The valid line is only lowered when a gap is drawn, so
  // that back-to-back words keep it high without a second assignment in the same step.
  task automatic send_word(input logic pwm, input logic tick, input logic tach,
                           input logic [1:0] enc);
    int gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.pwm_tick   <= pwm;
    item_if.timer_tick <= tick;
    item_if.tach_edge  <= tach;
    item_if.enc_step   <= enc;
    do @(posedge clk_i); while (!item_if.ready);
  endtask

  // Draws the ticks and the encoder step of one word from the current phase shaping.
  // Encoder steps mostly follow the phase's bias so that the duty reaches its limits.
  task automatic send_random(input logic tach);
    int         r;
    logic [1:0] enc;
    r = $urandom_range(0, 9);
    if (r < 5)
      enc = ENC_NONE;
    else if (r < 8)
      enc = (enc_bias == ENC_NONE) ?
            ($urandom_range(0, 1) ? fpt_pkg::ENC_DEC : fpt_pkg::ENC_INC) : enc_bias;
    else if (r < 9)
      enc = (enc_bias == fpt_pkg::ENC_INC) ? fpt_pkg::ENC_DEC : fpt_pkg::ENC_INC;
    else
      enc = ENC_CODE3;
    send_word($urandom_range(1, 4) <= pwm_odds, $urandom_range(1, 4) <= tick_odds, tach, enc);
  endtask

  // Waits until every status word has come back. A tach word keeps the divider busy, but
  // its status word is only published at the end, so an empty scoreboard already means an
  // idle block; a few spare cycles are added regardless.
  task automatic drain();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges; the enable stays high throughout.
  task automatic load_settings(input logic [fpt_pkg::TOP_W-1:0] top,
                               input logic [fpt_pkg::NUM_W-1:0] num,
                               input logic [fpt_pkg::THR_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_idx   <= fpt_pkg::REG_PWM_TOP;
    cfg_wdata <= fpt_pkg::CFG_DATA_W'(top);
    @(posedge clk_i);
    cfg_idx   <= fpt_pkg::REG_RPM_NUMERATOR;
    cfg_wdata <= fpt_pkg::CFG_DATA_W'(num);
    @(posedge clk_i);
    cfg_idx   <= fpt_pkg::REG_OK_THRESHOLD;
    cfg_wdata <= fpt_pkg::CFG_DATA_W'(thr);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // The receiving side: before each status word it holds ready low for a drawn number of
  // cycles, then keeps it high until the word is taken.
  initial begin : result_sink
    int stall;
    result_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = sink_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(result_if.valid && result_if.ready));
    end
  end

  initial begin : stimulus
    logic [fpt_pkg::TOP_W-1:0] top;
    logic [fpt_pkg::NUM_W-1:0] num;
    logic [fpt_pkg::THR_W-1:0] thr;
    longint                    typical_rpm;
    int                        rev_max;
    int                        n_words;

    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= fpt_pkg::REG_PWM_TOP;
    cfg_wdata          <= '0;
    item_if.valid      <= 1'b0;
    item_if.pwm_tick   <= 1'b0;
    item_if.timer_tick <= 1'b0;
    item_if.tach_edge  <= 1'b0;
    item_if.enc_step   <= ENC_NONE;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    pwm_odds  = 3;
    tick_odds = 3;
    enc_bias  = ENC_NONE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset settings. The unused encoder code must leave the duty
    // alone. The first tach edge captures a period of two ticks, the second one right
    // after it a period of zero, which must read as full-scale rpm. Then an edge and a
    // timer tick arrive together: the tick has to start the new period.
    send_word(1'b1, 1'b0, 1'b0, ENC_CODE3);
    send_word(1'b1, 1'b1, 1'b0, fpt_pkg::ENC_DEC);
    send_word(1'b1, 1'b1, 1'b0, fpt_pkg::ENC_INC);
    send_word(1'b0, 1'b0, 1'b1, ENC_NONE);
    send_word(1'b0, 1'b0, 1'b1, ENC_NONE);
    send_word(1'b1, 1'b1, 1'b1, ENC_NONE);
    send_word(1'b1, 1'b1, 1'b0, ENC_NONE);
    send_word(1'b0, 1'b0, 1'b1, fpt_pkg::ENC_INC);

    // A top of zero while the counter is part way up: the counter must turn round
    // without stepping, then count down from there. The duty is clamped to zero and a
    // decrease at zero must stay there. A zero numerator gives zero rpm, which a zero
    // threshold still reports as a healthy fan.
    drain();
    load_settings('0, '0, '0);
    send_word(1'b1, 1'b0, 1'b0, fpt_pkg::ENC_DEC);
    send_word(1'b1, 1'b1, 1'b0, fpt_pkg::ENC_DEC);
    send_word(1'b1, 1'b1, 1'b0, fpt_pkg::ENC_INC);
    send_word(1'b1, 1'b0, 1'b1, ENC_NONE);
    send_word(1'b1, 1'b0, 1'b0, ENC_NONE);

    // Largest top and threshold and a large numerator: a one-tick period saturates the
    // quotient and a full-scale rpm must still meet the largest threshold.
    drain();
    load_settings('1, fpt_pkg::NUM_W'(1_000_000_000), '1);
    send_word(1'b1, 1'b1, 1'b0, fpt_pkg::ENC_INC);
    send_word(1'b1, 1'b1, 1'b1, fpt_pkg::ENC_INC);
    send_word(1'b0, 1'b0, 1'b1, ENC_NONE);

    // Smallest legal top and numerator: the duty cannot climb past a top of one, and a
    // numerator of one over two ticks floors to zero rpm against the largest threshold.
    drain();
    load_settings(fpt_pkg::TOP_W'(1), fpt_pkg::NUM_W'(1), '1);
    send_word(1'b1, 1'b1, 1'b0, fpt_pkg::ENC_INC);
    send_word(1'b1, 1'b1, 1'b0, fpt_pkg::ENC_INC);
    send_word(1'b1, 1'b0, 1'b1, ENC_NONE);
    send_word(1'b1, 1'b1, 1'b0, fpt_pkg::ENC_DEC);

    // Random phases. Each one picks settings and a typical revolution length, then sends
    // whole revolutions: a run of ticking words closed by a tach edge. Now and then an
    // edge falls inside a run, which breaks the revolution short. The numerator is often
    // scaled to the revolution length so that rpm lands away from saturation and near the
    // threshold, and the idling of each side changes from phase to phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      rev_max = ($urandom_range(0, 2) == 0) ? 3 : ($urandom_range(0, 1) ? 30 : 300);
      case ($urandom_range(0, 2))
        0:       num = fpt_pkg::NUM_W'($urandom_range(1, 1_000_000_000));
        1:       num = fpt_pkg::NUM_W'($urandom_range(1, 65535 * rev_max));
        default: num = fpt_pkg::NUM_W'($urandom_range(1, 64));
      endcase
      top = $urandom_range(0, 1) ? fpt_pkg::TOP_W'($urandom_range(1, 255)) :
                                   fpt_pkg::TOP_W'($urandom_range(1, 8));
      typical_rpm = longint'(num) / (rev_max / 2 + 1);
      if ($urandom_range(0, 1))
        thr = fpt_pkg::THR_W'($urandom_range(0, 65535));
      else
        thr = (typical_rpm > 65535) ? '1 : fpt_pkg::THR_W'(typical_rpm);
      pwm_odds  = $urandom_range(1, 4);
      tick_odds = $urandom_range(1, 4);
      case ($urandom_range(0, 2))
        0:       enc_bias = fpt_pkg::ENC_DEC;
        1:       enc_bias = fpt_pkg::ENC_INC;
        default: enc_bias = ENC_NONE;
      endcase

      // The first phases take the extremes of the registers.
      if (ph == 0) begin
        top      = '1;
        num      = fpt_pkg::NUM_W'(1_000_000_000);
        thr      = '1;
        pwm_odds = 4;
        enc_bias = fpt_pkg::ENC_INC;
      end else if (ph == 1) begin
        top = fpt_pkg::TOP_W'(1);
        num = fpt_pkg::NUM_W'(1);
        thr = '0;
      end else if (ph == 2) begin
        top = '1;
        num = '1;
        thr = '0;
      end

      drain();
      load_settings(top, num, thr);
      src_idle  = (ph % 3) != 0;
      sink_idle = (ph % 4) != 1;

      n_words = 0;
      while (n_words < PHASE_WORDS) begin
        repeat ($urandom_range(0, rev_max)) begin
          send_random($urandom_range(0, 59) == 0);
          n_words++;
        end
        send_random(1'b1);
        n_words++;
      end
    end

    // Let the last status words come back, then allow the divider's latency over again.
    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("fan_pwm_tach_monitor_test OK");
    else
      $display("fan_pwm_tach_monitor_test NOT OK");
    $finish;
  end

  // Watchdog: a correct run needs well under a fifth of this.
  initial begin : watchdog
    #(10_000_000);
    $display("fan_pwm_tach_monitor_test NOT OK");
    $finish;
  end

endmodule
